### src/kmx_pkg.sv
// ----------------------------------------------------------------------------
// kmx_pkg
// Shared constants and types for the k-mer minimizer extractor.
// ----------------------------------------------------------------------------
package kmx_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int MAX_K      = 32;

  localparam int BASE_W      = 8;
  localparam int COLOR_W     = 16;
  localparam int KMER_W      = 64;
  localparam int KLEN_W      = 6;
  localparam int WSIZE_W     = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 2;

  localparam int WIN_AW = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int FILL_W = $clog2(MAX_K + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_KMER_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 2'd1;

  localparam logic [KLEN_W-1:0]  KLEN_RESET  = 6'd31;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd16;

  // Queue entry between front and back.
  typedef struct packed {
    logic               clear;  // drop the window before this entry
    logic               push;   // kmer enters the window
    logic [KMER_W-1:0]  kmer;
    logic [COLOR_W-1:0] color;
  } kmx_op_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } kmx_back_stat_t;

endpackage

### src/kmx_front.sv
// ----------------------------------------------------------------------------
// kmx_front
// Decodes bases, builds the k-mer and hands window work to the queue.
// ----------------------------------------------------------------------------
module kmx_front import kmx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  logic [FILL_W-1:0]   k_eff,
  input  logic                base_valid,
  output logic                base_stall,
  input  logic [BASE_W-1:0]   base_char,
  input  logic                seq_start,
  input  logic [COLOR_W-1:0]  color_id,
  input  logic                q_full,
  output logic                q_push,
  output kmx_op_t             q_op
);

  localparam logic [BASE_W-1:0] CH_A = 8'h41;
  localparam logic [BASE_W-1:0] CH_C = 8'h43;
  localparam logic [BASE_W-1:0] CH_G = 8'h47;
  localparam logic [BASE_W-1:0] CH_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Two mask bits per base position below k.
  function automatic logic [KMER_W-1:0] kmer_mask(input logic [FILL_W-1:0] k);
    logic [KMER_W-1:0] m;
    m = '0;
    for (int j = 0; j < KMER_W / 2; j++) begin
      m[2*j +: 2] = (FILL_W'(j) < k) ? 2'b11 : 2'b00;
    end
    return m;
  endfunction

  logic [KMER_W-1:0] kmer_shift;
  logic [KMER_W-1:0] kmer_shift_next;
  logic [FILL_W-1:0] bases_filled;
  logic [FILL_W-1:0] bases_filled_next;
  logic [FILL_W-1:0] fill_base;
  logic [1:0]        code;
  logic              base_ok;
  logic              accept;

  always_comb begin
    unique case (base_char)
      CH_A: begin code = CODE_A; base_ok = 1'b1; end
      CH_C: begin code = CODE_C; base_ok = 1'b1; end
      CH_G: begin code = CODE_G; base_ok = 1'b1; end
      CH_T: begin code = CODE_T; base_ok = 1'b1; end
      default: begin code = CODE_A; base_ok = 1'b0; end
    endcase
  end

  assign base_stall = q_full;
  assign accept     = base_valid && !q_full;

  always_comb begin
    fill_base         = seq_start ? '0 : bases_filled;
    bases_filled_next = (fill_base < k_eff) ? fill_base + 1'b1 : fill_base;
    kmer_shift_next   = {kmer_shift[KMER_W-3:0], code} & kmer_mask(k_eff);
  end

  assign q_op.clear = seq_start || !base_ok;
  assign q_op.push  = base_ok && (bases_filled_next >= k_eff);
  assign q_op.kmer  = kmer_shift_next;
  assign q_op.color = color_id;
  assign q_push     = accept && (q_op.clear || q_op.push);

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_shift   <= '0;
      bases_filled <= '0;
    end else if (cfg_clear) begin
      bases_filled <= '0;
    end else if (accept) begin
      if (base_ok) begin
        kmer_shift   <= kmer_shift_next;
        bases_filled <= bases_filled_next;
      end else begin
        bases_filled <= '0;
      end
    end
  end

endmodule

### src/kmx_queue.sv
// ----------------------------------------------------------------------------
// kmx_queue
// Two-entry FIFO that decouples the front end from the window back end.
// ----------------------------------------------------------------------------
module kmx_queue import kmx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  kmx_op_t op_in,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output kmx_op_t op_out
);

  kmx_op_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full   = (fill == 2'd2);
  assign valid  = (fill != 2'd0);
  assign op_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### src/kmx_back.sv
// ----------------------------------------------------------------------------
// kmx_back
// Window store and minimum scan; one queue entry at a time.
// ----------------------------------------------------------------------------
module kmx_back import kmx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  logic [CNT_W-1:0]    w_eff,
  input  logic                op_valid,
  input  kmx_op_t             op,
  output logic                op_pop,
  output logic                min_valid,
  input  logic                min_stall,
  output logic [KMER_W-1:0]   minimizer,
  output logic [COLOR_W-1:0]  color_out,
  output kmx_back_stat_t      stat
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // Ring index add with one wrap correction.
  function automatic logic [WIN_AW-1:0] win_wrap(input logic [WIN_AW-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_WINDOW)) begin
      sum = sum - (CNT_W+1)'(MAX_WINDOW);
    end
    return sum[WIN_AW-1:0];
  endfunction

  logic [KMER_W-1:0] win_mem [MAX_WINDOW];

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [WIN_AW-1:0]  head;
  logic [CNT_W-1:0]   issue_idx;
  logic               rd_pend;
  logic               rd_first;
  logic [KMER_W-1:0]  rd_data;
  logic [KMER_W-1:0]  fresh;
  logic [COLOR_W-1:0] color;
  logic [KMER_W-1:0]  min_all;
  logic [KMER_W-1:0]  min_rest;
  logic               rest_any;
  logic [KMER_W-1:0]  oldest;

  logic               evict;
  logic               issue;
  logic               out_free;
  logic               finish_go;
  logic               below_all;
  logic               changed;
  logic [CNT_W-1:0]   count_next;
  logic               emit;
  logic [KMER_W-1:0]  min_out;
  logic [WIN_AW-1:0]  rd_addr;
  logic [WIN_AW-1:0]  wr_addr;

  assign evict     = (count >= w_eff);
  assign issue     = (state == ST_SCAN) && (issue_idx < count);
  assign out_free  = !min_valid || !min_stall;
  assign finish_go = (state == ST_FINISH) && out_free;
  assign op_pop    = (state == ST_IDLE) && op_valid;
  assign rd_addr   = win_wrap(head, issue_idx);
  // head + count is the new tail slot with or without an eviction
  assign wr_addr   = win_wrap(head, count);

  assign below_all  = !rest_any || (min_rest > fresh);
  assign changed    = !evict || (oldest == min_all) || below_all;
  assign count_next = count - CNT_W'(evict) + 1'b1;
  assign emit       = (count_next == w_eff) && changed;
  assign min_out    = (min_rest < fresh) ? min_rest : fresh;

  assign stat.idle  = (state == ST_IDLE);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (finish_go) begin
      win_mem[wr_addr] <= fresh;
    end
    if (issue) begin
      rd_data <= win_mem[rd_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (op_pop) begin
      fresh    <= op.kmer;
      color    <= op.color;
      min_all  <= '1;
      min_rest <= '1;
      rest_any <= 1'b0;
    end else if (rd_pend) begin
      if (rd_data < min_all) begin
        min_all <= rd_data;
      end
      if (!(evict && rd_first)) begin
        rest_any <= 1'b1;
        if (rd_data < min_rest) begin
          min_rest <= rd_data;
        end
      end
    end
    if (rd_pend && rd_first) begin
      oldest <= rd_data;
    end
    if (issue) begin
      rd_first <= (issue_idx == '0);
    end
    if (finish_go && emit) begin
      minimizer <= min_out;
      color_out <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      head      <= '0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      min_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (min_valid && !min_stall) begin
        min_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (op_valid) begin
            if (op.clear) begin
              count <= '0;
              head  <= '0;
            end
            if (op.push) begin
              issue_idx <= '0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            issue_idx <= issue_idx + 1'b1;
          end else if (!rd_pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            count <= count_next;
            if (evict) begin
              head <= win_wrap(head, CNT_W'(1));
            end
            if (emit) begin
              min_valid <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_clear) begin
        count <= '0;
        head  <= '0;
      end
    end
  end

endmodule

### src/kmer_minimizer_extractor_unit.sv
// ----------------------------------------------------------------------------
// kmer_minimizer_extractor_unit
// Window k-mer minimizer over a stream of ASCII DNA bases.
// ----------------------------------------------------------------------------
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  cfg      cfg_wr_en, cfg_index, cfg_data            in
//  base     base_valid/base_stall, base_char,         in
//           seq_start, color_id
//  min      min_valid/min_stall, minimizer,           out
//           color_out
//
//  Work: a base that does not put a k-mer in the window needs no window
//  scan in the back end. A k-mer transaction in the back end reads every
//  window entry held before it through the single read port of the window
//  memory, scanned once per k-mer, then writes the new k-mer into the ring.
//  Reset: rst is synchronous; registers go to k = 31, W = 16, window empty.
//  Stalls: a two-entry queue lets the front keep taking bases while the back
//  scans; base_stall rises only when that queue is full. The result register
//  holds one minimizer while min_stall is high.
// ----------------------------------------------------------------------------
module kmer_minimizer_extractor_unit import kmx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // base stream
  input  logic                   base_valid,
  output logic                   base_stall,
  input  logic [BASE_W-1:0]      base_char,
  input  logic                   seq_start,
  input  logic [COLOR_W-1:0]     color_id,
  // minimizer results
  output logic                   min_valid,
  input  logic                   min_stall,
  output logic [KMER_W-1:0]      minimizer,
  output logic [COLOR_W-1:0]     color_out
);

  logic [KLEN_W-1:0]  kmer_length;
  logic [WSIZE_W-1:0] window_size;
  logic [FILL_W-1:0]  k_eff;
  logic [CNT_W-1:0]   w_eff;
  logic               cfg_hit;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  kmx_op_t            q_in;
  kmx_op_t            q_out;
  kmx_back_stat_t     back_stat;

  // Any write to a known register also restarts k-mer filling and the window.
  assign cfg_hit = cfg_wr_en &&
                   ((cfg_index == REG_KMER_LENGTH) || (cfg_index == REG_WINDOW_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KLEN_RESET;
      window_size <= WSIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KMER_LENGTH: kmer_length <= cfg_data[KLEN_W-1:0];
        REG_WINDOW_SIZE: window_size <= cfg_data[WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range lengths clamp: zero acts as one, large values as the maximum.
  always_comb begin
    if (kmer_length == '0) begin
      k_eff = FILL_W'(1);
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_eff = FILL_W'(MAX_K);
    end else begin
      k_eff = FILL_W'(kmer_length);
    end
    if (window_size == '0) begin
      w_eff = CNT_W'(1);
    end else if (window_size > WSIZE_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(window_size);
    end
  end

  // Front end: base decode, k-mer shift register, fill count.
  kmx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_hit),
    .k_eff      (k_eff),
    .base_valid (base_valid),
    .base_stall (base_stall),
    .base_char  (base_char),
    .seq_start  (seq_start),
    .color_id   (color_id),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (q_in)
  );

  kmx_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .op_in  (q_in),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .op_out (q_out)
  );

  // Back end: window ring in memory, scan for minimum, result register.
  kmx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_hit),
    .w_eff     (w_eff),
    .op_valid  (q_valid),
    .op        (q_out),
    .op_pop    (q_pop),
    .min_valid (min_valid),
    .min_stall (min_stall),
    .minimizer (minimizer),
    .color_out (color_out),
    .stat      (back_stat)
  );

`ifndef SYNTH
  // The window never holds more k-mers than the window size.
  a_count_le_window: assert property (@(posedge clk) disable iff (rst)
    back_stat.count <= w_eff)
    else $error("window count above window size");

  // Only entries that do window work are queued.
  a_queue_useful: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_out.clear || q_out.push))
    else $error("empty entry in queue");

  // A register write empties the window.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (back_stat.count == '0))
    else $error("window not cleared by register write");

  // A new result appears only at the end of a scan.
  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(min_valid) |-> $past(!back_stat.idle))
    else $error("result without scan");
`endif

endmodule
